FILE: hdl/aaq_pkg.sv
package aaq_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int INNER_FRAC    = 30;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int IDX_W         = $clog2(TABLE_LEN);
  localparam int FIELD_W       = 16;
  localparam int XY_W          = INNER_FRAC + 3;
  localparam int Z_W           = 32;
  localparam int RND_SH        = INNER_FRAC - FRAC_BITS;

  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(652032874);

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic [1:0]                quad;
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
  } cord_t;

  // atan(2^-i) as a phase, one full turn = 2^32.
  function automatic logic signed [Z_W-1:0] atan_phase(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:    r = Z_W'(536870912);
      5'd1:    r = Z_W'(316933406);
      5'd2:    r = Z_W'(167458907);
      5'd3:    r = Z_W'(85004756);
      5'd4:    r = Z_W'(42667331);
      5'd5:    r = Z_W'(21354465);
      5'd6:    r = Z_W'(10679838);
      5'd7:    r = Z_W'(5340245);
      5'd8:    r = Z_W'(2670163);
      5'd9:    r = Z_W'(1335087);
      5'd10:   r = Z_W'(667544);
      5'd11:   r = Z_W'(333772);
      5'd12:   r = Z_W'(166886);
      5'd13:   r = Z_W'(83443);
      5'd14:   r = Z_W'(41722);
      5'd15:   r = Z_W'(20861);
      5'd16:   r = Z_W'(10430);
      5'd17:   r = Z_W'(5215);
      5'd18:   r = Z_W'(2608);
      5'd19:   r = Z_W'(1304);
      5'd20:   r = Z_W'(652);
      5'd21:   r = Z_W'(326);
      5'd22:   r = Z_W'(163);
      5'd23:   r = Z_W'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/axis_angle_to_quaternion.sv
// Channel   Dir  Word bits (lowest first)
// s_axis    in   angle_code[15:0] axis_x[31:16] axis_y[47:32] axis_z[63:48]
// m_axis    out  quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
//
// One word enters per cycle while the pipeline advances; each result passes
// an input register, a register per CORDIC cell (16 cells), a rounding stage
// and a multiply stage. The whole pipeline advances when the output register is
// empty or being taken, so s_tready follows m_tready while a result waits.
// Synchronous reset clears the valid bits of every stage; no other state.
module axis_angle_to_quaternion (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // angle_code, axis_x, axis_y, axis_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);
  import aaq_pkg::*;

  logic                      en;
  logic [FIELD_W-1:0]        angle_code;
  logic [FIELD_W-1:0]        resid;
  logic [1:0]                quad;
  cord_t                     prep_next;
  logic                      cv [0:NUM_CELLS];
  cord_t                     cd [0:NUM_CELLS];
  logic signed [FIELD_W-1:0] quat_w;
  logic signed [FIELD_W-1:0] quat_x;
  logic signed [FIELD_W-1:0] quat_y;
  logic signed [FIELD_W-1:0] quat_z;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // The top two bits of the phase, offset by an eighth turn, pick the
  // quadrant; the rest is a residual in [-pi/4, pi/4).
  always_comb begin
    angle_code       = s_tdata[15:0];
    quad             = angle_code[15:14] + {1'b0, angle_code[13]};
    resid            = angle_code - {quad, {(FIELD_W-2){1'b0}}};
    prep_next.x      = INV_GAIN;
    prep_next.y      = '0;
    prep_next.z      = {resid, {(Z_W-FIELD_W){1'b0}}};
    prep_next.quad   = quad;
    prep_next.ax     = s_tdata[31:16];
    prep_next.ay     = s_tdata[47:32];
    prep_next.az     = s_tdata[63:48];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= prep_next;
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    aaq_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (IDX_W'(i)),
      .in_valid  (cv[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_data  (cd[i+1])
    );
  end

  aaq_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv[NUM_CELLS]),
    .in_data   (cd[NUM_CELLS]),
    .out_valid (m_tvalid),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z)
  );

  assign m_tdata = {quat_z, quat_y, quat_x, quat_w};

endmodule

FILE: hdl/aaq_cordic_cell.sv
module aaq_cordic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [aaq_pkg::IDX_W-1:0]  idx,
  input  logic                       in_valid,
  input  aaq_pkg::cord_t             in_data,
  output logic                       out_valid,
  output aaq_pkg::cord_t             out_data
);
  import aaq_pkg::*;

  cord_t                  data_next;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  ang;

  // The index is tied to a constant per cell, so the shifts reduce to wiring.
  always_comb begin
    xs        = in_data.x >>> idx;
    ys        = in_data.y >>> idx;
    ang       = atan_phase(idx);
    data_next = in_data;
    if (!in_data.z[Z_W-1]) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ang;
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: hdl/aaq_post.sv
module aaq_post (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  aaq_pkg::cord_t                     in_data,
  output logic                               out_valid,
  output logic signed [aaq_pkg::FIELD_W-1:0] quat_w,
  output logic signed [aaq_pkg::FIELD_W-1:0] quat_x,
  output logic signed [aaq_pkg::FIELD_W-1:0] quat_y,
  output logic signed [aaq_pkg::FIELD_W-1:0] quat_z
);
  import aaq_pkg::*;

  localparam int SUM_W  = XY_W + 1;
  localparam int RND_W  = SUM_W - RND_SH;
  localparam int PROD_W = 2 * FIELD_W;

  localparam logic signed [RND_W-1:0] LIM_P = RND_W'(1) <<< FRAC_BITS;
  localparam logic signed [RND_W-1:0] LIM_N = -LIM_P;

  logic signed [XY_W-1:0]    c_rot;
  logic signed [XY_W-1:0]    s_rot;
  logic signed [SUM_W-1:0]   c_sum;
  logic signed [SUM_W-1:0]   s_sum;
  logic signed [RND_W-1:0]   c_rnd;
  logic signed [RND_W-1:0]   s_rnd;
  logic signed [FIELD_W-1:0] w_next;
  logic signed [FIELD_W-1:0] s_next;

  logic                      v1;
  logic signed [FIELD_W-1:0] w1;
  logic signed [FIELD_W-1:0] s1;
  logic signed [FIELD_W-1:0] ax1;
  logic signed [FIELD_W-1:0] ay1;
  logic signed [FIELD_W-1:0] az1;

  logic signed [PROD_W-1:0]  px;
  logic signed [PROD_W-1:0]  py;
  logic signed [PROD_W-1:0]  pz;

  // Map the residual rotation back to the quadrant of the half angle,
  // then round half up to FRAC_BITS and clamp to plus or minus one.
  always_comb begin
    unique case (in_data.quad)
      2'd1: begin
        c_rot = -in_data.y;
        s_rot = in_data.x;
      end
      2'd2: begin
        c_rot = -in_data.x;
        s_rot = -in_data.y;
      end
      2'd3: begin
        c_rot = in_data.y;
        s_rot = -in_data.x;
      end
      default: begin
        c_rot = in_data.x;
        s_rot = in_data.y;
      end
    endcase
    c_sum = SUM_W'(c_rot) + (SUM_W'(1) <<< (RND_SH - 1));
    s_sum = SUM_W'(s_rot) + (SUM_W'(1) <<< (RND_SH - 1));
    c_rnd = RND_W'(c_sum >>> RND_SH);
    s_rnd = RND_W'(s_sum >>> RND_SH);
    priority if (c_rnd > LIM_P) begin
      w_next = FIELD_W'(LIM_P);
    end else if (c_rnd < LIM_N) begin
      w_next = FIELD_W'(LIM_N);
    end else begin
      w_next = FIELD_W'(c_rnd);
    end
    priority if (s_rnd > LIM_P) begin
      s_next = FIELD_W'(LIM_P);
    end else if (s_rnd < LIM_N) begin
      s_next = FIELD_W'(LIM_N);
    end else begin
      s_next = FIELD_W'(s_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1  <= w_next;
      s1  <= s_next;
      ax1 <= in_data.ax;
      ay1 <= in_data.ay;
      az1 <= in_data.az;
    end
  end

  always_comb begin
    px = (PROD_W'(s1) * PROD_W'(ax1)) + (PROD_W'(1) <<< (FRAC_BITS - 1));
    py = (PROD_W'(s1) * PROD_W'(ay1)) + (PROD_W'(1) <<< (FRAC_BITS - 1));
    pz = (PROD_W'(s1) * PROD_W'(az1)) + (PROD_W'(1) <<< (FRAC_BITS - 1));
  end

  // A vector part that leaves 16 bits wraps.
  always_ff @(posedge clk) begin
    if (en) begin
      quat_w <= w1;
      quat_x <= px[FRAC_BITS +: FIELD_W];
      quat_y <= py[FRAC_BITS +: FIELD_W];
      quat_z <= pz[FRAC_BITS +: FIELD_W];
    end
  end

endmodule
